### hdl/pma_pkg.sv
// Shared types, constants and coefficient tables for the Planck mean absorption pipeline.
// Depends on nothing; every other file of the block but pma_div imports it.
`default_nettype none

package pma_pkg;

	typedef enum logic [1:0] {
		SPEC_CH4 = 2'd0,
		SPEC_CO2 = 2'd1,
		SPEC_H2O = 2'd2,
		SPEC_CO  = 2'd3
	} spec_t;

	typedef logic signed [63:0] coef_arr_t [6];

	localparam int T_W      = 16;
	localparam int FRAC_W   = 16;
	localparam int X_W      = 26;
	localparam int PATM_W   = 32;
	localparam int PRES_W   = 24;
	localparam int SPEC_N   = 4;
	localparam int KABS_W   = 40;
	localparam int ACC_W    = 64;
	localparam int DEN_W    = 17;
	localparam int SIDE_W   = T_W + 4 * FRAC_W;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam int DIV_STAGES   = 32;
	localparam int MULR_STAGES  = 4;
	localparam int HORNER_STEPS = 5;
	localparam int LANE_LAT     = (HORNER_STEPS + 2) * MULR_STAGES;
	localparam int SUM_STAGES   = 2;
	localparam int PIPE_LAT     = 1 + DIV_STAGES + LANE_LAT + SUM_STAGES;

	localparam int SH_T    = 14;
	localparam int SH_X    = 16;
	localparam int SH_FRAC = 16;
	localparam int SH_PATM = 40;
	localparam int LIMW_ACC  = 62;
	localparam int LIMW_TERM = 60;

	localparam logic [T_W-1:0]    T_MIN       = 16'd16;
	localparam logic [T_W-1:0]    T_CO_SPLIT  = 16'd12000;
	localparam logic [32:0]       X_NUM       = 33'd2097152000;
	localparam logic [47:0]       P_ROUND     = 48'd50662;
	localparam logic [DEN_W-1:0]  P_ATM_PA    = 17'd101325;
	localparam logic [47:0]       P_RECIP     = 48'(64'hFFFF_FFFF_FFFF_FFFF / 64'd101325);
	localparam logic [3:0]        SPEC_RESET  = 4'hF;
	localparam logic [PRES_W-1:0] PRES_RESET  = 24'd101325;
	localparam logic signed [ACC_W-1:0] KABS_MAX = 64'sd549755813887;
	localparam logic signed [ACC_W-1:0] KABS_MIN = -64'sd549755813888;

	localparam logic [0:0] REG_SPECIES  = 1'b0;
	localparam logic [0:0] REG_PRESSURE = 1'b1;

	localparam coef_arr_t COEF_CH4 = '{
		64'sd28490236061, -64'sd15694868780, 64'sd75129049, 64'sd1181098906,
		-64'sd125416609, 64'sd0};
	localparam coef_arr_t COEF_CO_LOW = '{
		64'sd20559578949, -64'sd305796173917, 64'sd1332052179785,
		-64'sd1963342311998, 64'sd958139825175, 64'sd0};
	localparam coef_arr_t COEF_CO_HIGH = '{
		64'sd43336220017, -64'sd52028890226, 64'sd21506039300,
		-64'sd2708023535, -64'sd119636432, 64'sd0};
	localparam coef_arr_t COEF_CO2 = '{
		64'sd80491982094, -64'sd521022482678, 64'sd1174673555456,
		-64'sd833438403789, 64'sd241849608438, -64'sd24983395265};
	localparam coef_arr_t COEF_H2O = '{
		-64'sd991836798, -64'sd4827113744, 64'sd40438405583,
		-64'sd12879747927, 64'sd2206840096, -64'sd80247};

	// Coefficient of the given power; the degree-four fits carry a zero top entry.
	function automatic logic signed [63:0] pma_coef(spec_t s, logic hi, logic [2:0] idx);
		logic signed [63:0] v;
		v = '0;
		if (idx <= 3'd5) begin
			unique case (s)
				SPEC_CH4: v = COEF_CH4[idx];
				SPEC_CO2: v = COEF_CO2[idx];
				SPEC_H2O: v = COEF_H2O[idx];
				SPEC_CO:  v = hi ? COEF_CO_HIGH[idx] : COEF_CO_LOW[idx];
				default:  v = '0;
			endcase
		end
		return v;
	endfunction

endpackage

`default_nettype wire

### hdl/pma_div.sv
// Pipelined restoring divider: one quotient bit per register stage, side data alongside.
// Uses no package; the quotient must be known to fit in QW bits.
`default_nettype none

module pma_div #(
	parameter int NW = 33,
	parameter int DW = 17,
	parameter int QW = 32,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side,
	output logic      [QW-1:0] quo,
	output logic      [SW-1:0] side_out
);

	logic [DW-1:0] rem_s  [QW];
	logic [NW-1:0] num_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [SW-1:0] side_s [QW];

	logic [DW-1:0] rem_in  [QW];
	logic [NW-1:0] num_in  [QW];
	logic [QW-1:0] quo_in  [QW];
	logic [DW-1:0] den_in  [QW];
	logic [SW-1:0] side_in [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0] rs;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_in[k]  = DW'(num[NW-1:QW]);
			assign num_in[k]  = num;
			assign quo_in[k]  = '0;
			assign den_in[k]  = den;
			assign side_in[k] = side;
		end else begin : g_next
			assign rem_in[k]  = rem_s[k-1];
			assign num_in[k]  = num_s[k-1];
			assign quo_in[k]  = quo_s[k-1];
			assign den_in[k]  = den_s[k-1];
			assign side_in[k] = side_s[k-1];
		end

		assign rs = {rem_in[k], num_in[k][QW-1-k]};
		assign ge = rs >= {1'b0, den_in[k]};

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? DW'(rs - {1'b0, den_in[k]}) : DW'(rs);
			num_s[k]  <= num_in[k];
			quo_s[k]  <= quo_in[k] | (QW'(ge) << (QW - 1 - k));
			den_s[k]  <= den_in[k];
			side_s[k] <= side_in[k];
		end
	end

	assign quo      = quo_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

`default_nettype wire

### hdl/pma_mulr.sv
// Four-stage signed multiply, round to nearest by magnitude, saturate, add and clamp.
// Uses pma_pkg for the accumulator width; the magnitude of a stays within 2^62.
`default_nettype none

module pma_mulr #(
	parameter int BW   = 16,
	parameter int SH   = 14,
	parameter int LIMW = 62
) (
	input  wire logic                            clk,
	input  wire logic signed [pma_pkg::ACC_W-1:0] a,
	input  wire logic        [BW-1:0]             b,
	input  wire logic signed [pma_pkg::ACC_W-1:0] c,
	output logic signed      [pma_pkg::ACC_W-1:0] r
);
	import pma_pkg::*;

	localparam int PLW = 32 + BW + 1;
	localparam int PHW = 31 + BW;
	localparam int FW  = 64 + BW;
	localparam logic [PLW-1:0]  HALF = PLW'(1) << (SH - 1);
	localparam logic [LIMW:0]   LIM  = (LIMW + 1)'(1) << LIMW;
	localparam logic signed [ACC_W-1:0] LIMV = ACC_W'(LIM);

	logic              neg_s1, neg_s2, neg_s3;
	logic [62:0]       mag_s1;
	logic [BW-1:0]     b_s1;
	logic signed [ACC_W-1:0] c_s1, c_s2, c_s3, r_s4;
	logic [PLW-1:0]    pl_s2;
	logic [PHW-1:0]    ph_s2;
	logic [LIMW:0]     q_s3;
	logic [ACC_W-1:0]  a_abs;
	logic [FW-1:0]     full, qf;
	logic signed [ACC_W-1:0] qe, sum;

	assign a_abs = a[ACC_W-1] ? (ACC_W'(0) - a) : a;

	always_ff @(posedge clk) begin
		neg_s1 <= a[ACC_W-1];
		mag_s1 <= a_abs[62:0];
		b_s1   <= b;
		c_s1   <= c;
	end

	always_ff @(posedge clk) begin
		pl_s2  <= PLW'(mag_s1[31:0]) * PLW'(b_s1) + HALF;
		ph_s2  <= PHW'(mag_s1[62:32]) * PHW'(b_s1);
		neg_s2 <= neg_s1;
		c_s2   <= c_s1;
	end

	always_comb begin
		full = FW'(pl_s2) + (FW'(ph_s2) << 32);
		qf   = full >> SH;
	end

	always_ff @(posedge clk) begin
		q_s3   <= (qf > FW'(LIM)) ? LIM : qf[LIMW:0];
		neg_s3 <= neg_s2;
		c_s3   <= c_s2;
	end

	always_comb begin
		qe  = $signed(ACC_W'(q_s3));
		sum = (neg_s3 ? -qe : qe) + c_s3;
	end

	always_ff @(posedge clk) begin
		if (sum > LIMV) begin
			r_s4 <= LIMV;
		end else if (sum < -LIMV) begin
			r_s4 <= -LIMV;
		end else begin
			r_s4 <= sum;
		end
	end

	assign r = r_s4;

endmodule

`default_nettype wire

### hdl/pma_lane.sv
// One species lane: a five-step Horner chain followed by the mole-fraction and pressure
// weightings, all built from pma_mulr. Uses pma_pkg for tables and widths.
`default_nettype none

module pma_lane #(
	parameter pma_pkg::spec_t SPEC = pma_pkg::SPEC_CH4,
	parameter int             BW   = 16,
	parameter int             SH   = 14
) (
	input  wire logic                             clk,
	input  wire logic        [BW-1:0]             v,
	input  wire logic                             hi,
	input  wire logic        [pma_pkg::FRAC_W-1:0] frac,
	input  wire logic        [pma_pkg::PATM_W-1:0] patm,
	output logic signed      [pma_pkg::ACC_W-1:0]  term
);
	import pma_pkg::*;

	localparam int VD = HORNER_STEPS * MULR_STAGES;
	localparam int PD = VD + MULR_STAGES;

	logic [BW-1:0]     v_q    [VD];
	logic              hi_q   [VD];
	logic [FRAC_W-1:0] frac_q [VD];
	logic [PATM_W-1:0] patm_q [PD];
	logic signed [ACC_W-1:0] acc [HORNER_STEPS+1];
	logic signed [ACC_W-1:0] wt;

	always_ff @(posedge clk) begin
		v_q[0]    <= v;
		hi_q[0]   <= hi;
		frac_q[0] <= frac;
		patm_q[0] <= patm;
		for (int i = 1; i < VD; i++) begin
			v_q[i]    <= v_q[i-1];
			hi_q[i]   <= hi_q[i-1];
			frac_q[i] <= frac_q[i-1];
		end
		for (int i = 1; i < PD; i++) begin
			patm_q[i] <= patm_q[i-1];
		end
	end

	assign acc[0] = pma_coef(SPEC, hi, 3'(HORNER_STEPS));

	for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
		logic [BW-1:0]           v_at;
		logic                    hi_at;
		logic signed [ACC_W-1:0] c_at;

		if (j == 0) begin : g_first
			assign v_at  = v;
			assign hi_at = hi;
		end else begin : g_next
			assign v_at  = v_q[j*MULR_STAGES-1];
			assign hi_at = hi_q[j*MULR_STAGES-1];
		end

		assign c_at = pma_coef(SPEC, hi_at, 3'(HORNER_STEPS - 1 - j));

		pma_mulr #(.BW(BW), .SH(SH), .LIMW(LIMW_ACC)) u_step (
			.clk (clk),
			.a   (acc[j]),
			.b   (v_at),
			.c   (c_at),
			.r   (acc[j+1])
		);
	end

	pma_mulr #(.BW(FRAC_W), .SH(SH_FRAC), .LIMW(LIMW_ACC)) u_frac (
		.clk (clk),
		.a   (acc[HORNER_STEPS]),
		.b   (frac_q[VD-1]),
		.c   ('0),
		.r   (wt)
	);

	pma_mulr #(.BW(PATM_W), .SH(SH_PATM), .LIMW(LIMW_TERM)) u_patm (
		.clk (clk),
		.a   (wt),
		.b   (patm_q[PD-1]),
		.c   ('0),
		.r   (term)
	);

endmodule

`default_nettype wire

### hdl/planck_mean_absorption.sv
// Throughput: one grid point per cycle; busy stays low and every result is a one-cycle transfer.
// The pipeline is the 32-stage divider for 1000/T, then five Horner steps and two
// weightings of four register stages each, then a two-stage sum and saturation.
// Reset clears the configuration to its defaults and empties the valid chain at once.
// Depends on pma_pkg, pma_div, pma_mulr and pma_lane.
`default_nettype none

module planck_mean_absorption (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic        [pma_pkg::T_W-1:0]    temperature,
	input  wire logic        [pma_pkg::FRAC_W-1:0] frac_ch4,
	input  wire logic        [pma_pkg::FRAC_W-1:0] frac_co2,
	input  wire logic        [pma_pkg::FRAC_W-1:0] frac_h2o,
	input  wire logic        [pma_pkg::FRAC_W-1:0] frac_co,
	input  wire logic                             final_point,
	output logic                                  done,
	output logic signed      [pma_pkg::KABS_W-1:0] kabs,
	output logic                                  final_point_out,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic        [pma_pkg::ADDR_W-1:0] paddr,
	input  wire logic        [pma_pkg::DATA_W-1:0] pwdata,
	output logic             [pma_pkg::DATA_W-1:0] prdata,
	output logic                                  pready
);
	import pma_pkg::*;

	localparam int VLD_N = PIPE_LAT - 1;
	localparam int FIN_N = LANE_LAT + 1;

	logic [SPEC_N-1:0] species_present_q;
	logic [PRES_W-1:0] pressure_pa_q;

	logic              vld_s1, fin_s1;
	logic [T_W-1:0]    t_s1;
	logic [FRAC_W-1:0] f_ch4_s1, f_co2_s1, f_h2o_s1, f_co_s1;
	logic              vld_q [VLD_N];
	logic              fin_q [FIN_N];

	logic [DIV_STAGES-1:0] x_quo;
	logic [SIDE_W:0]       side_out;
	logic                  fin_div;
	logic [T_W-1:0]        t_d;
	logic [FRAC_W-1:0]     f_ch4_d, f_co2_d, f_h2o_d, f_co_d;
	logic                  co_hi;
	logic signed [ACC_W-1:0] term [SPEC_N];
	logic signed [ACC_W-1:0] pair0_s1, pair1_s1, tot;
	logic signed [KABS_W-1:0] kabs_q;
	logic                     fin_out_q;

	logic [2*PRES_W-1:0]     p_num, p_rem;
	logic [2*PRES_W-1:0]     pn_s1, pn_s2, pn_s3, pn_s4;
	logic [2*PRES_W-1:0]     pp_hh_s1, pp_hl_s1, pp_lh_s1, pp_ll_s1;
	logic [2*PRES_W-1:0]     pp_hh_s2, pp_ll_s2;
	logic [2*PRES_W:0]       pp_mid_s2;
	logic [4*PRES_W:0]       p_full;
	logic [PATM_W-1:0]       pq_s3, pq_s4, patm_s5;
	logic [PATM_W+DEN_W-1:0] pqd_s4;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			species_present_q <= SPEC_RESET;
			pressure_pa_q     <= PRES_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_SPECIES:  species_present_q <= pwdata[SPEC_N-1:0];
				REG_PRESSURE: pressure_pa_q     <= pwdata[PRES_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SPECIES:  prdata = DATA_W'(species_present_q);
			REG_PRESSURE: prdata = DATA_W'(pressure_pa_q);
			default:      prdata = '0;
		endcase
	end

	// Pressure in atmospheres by reciprocal multiplication and one correction step. It only
	// changes after a register write and settles long before a new point reaches the lanes.
	assign p_num  = {pressure_pa_q, 24'd0} + P_ROUND;
	assign p_full = ((4*PRES_W+1)'(pp_hh_s2) << 48) + ((4*PRES_W+1)'(pp_mid_s2) << 24)
		+ (4*PRES_W+1)'(pp_ll_s2);
	assign p_rem  = pn_s4 - pqd_s4[2*PRES_W-1:0];

	always_ff @(posedge clk) begin
		pn_s1     <= p_num;
		pp_hh_s1  <= (2*PRES_W)'(p_num[47:24]) * (2*PRES_W)'(P_RECIP[47:24]);
		pp_hl_s1  <= (2*PRES_W)'(p_num[47:24]) * (2*PRES_W)'(P_RECIP[23:0]);
		pp_lh_s1  <= (2*PRES_W)'(p_num[23:0]) * (2*PRES_W)'(P_RECIP[47:24]);
		pp_ll_s1  <= (2*PRES_W)'(p_num[23:0]) * (2*PRES_W)'(P_RECIP[23:0]);
		pn_s2     <= pn_s1;
		pp_hh_s2  <= pp_hh_s1;
		pp_ll_s2  <= pp_ll_s1;
		pp_mid_s2 <= (2*PRES_W+1)'(pp_hl_s1) + (2*PRES_W+1)'(pp_lh_s1);
		pn_s3     <= pn_s2;
		pq_s3     <= p_full[95:64];
		pn_s4     <= pn_s3;
		pq_s4     <= pq_s3;
		pqd_s4    <= (PATM_W+DEN_W)'(pq_s3) * (PATM_W+DEN_W)'(P_ATM_PA);
		patm_s5   <= pq_s4 + PATM_W'(p_rem >= (2*PRES_W)'(P_ATM_PA));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < VLD_N; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_s1   <= start && !busy;
			vld_q[0] <= vld_s1;
			for (int i = 1; i < VLD_N; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		t_s1     <= (temperature < T_MIN) ? T_MIN : temperature;
		f_ch4_s1 <= frac_ch4;
		f_co2_s1 <= frac_co2;
		f_h2o_s1 <= frac_h2o;
		f_co_s1  <= frac_co;
		fin_s1   <= final_point;
	end

	pma_div #(.NW(33), .DW(DEN_W), .QW(DIV_STAGES), .SW(SIDE_W + 1)) u_div_x (
		.clk      (clk),
		.num      (X_NUM + 33'(t_s1)),
		.den      ({t_s1, 1'b0}),
		.side     ({t_s1, f_ch4_s1, f_co2_s1, f_h2o_s1, f_co_s1, fin_s1}),
		.quo      (x_quo),
		.side_out (side_out)
	);

	assign {t_d, f_ch4_d, f_co2_d, f_h2o_d, f_co_d, fin_div} = side_out;
	assign co_hi = t_d > T_CO_SPLIT;

	pma_lane #(.SPEC(SPEC_CH4), .BW(T_W), .SH(SH_T)) u_lane_ch4 (
		.clk (clk), .v (t_d), .hi (1'b0), .frac (f_ch4_d), .patm (patm_s5),
		.term (term[0])
	);

	pma_lane #(.SPEC(SPEC_CO2), .BW(X_W), .SH(SH_X)) u_lane_co2 (
		.clk (clk), .v (x_quo[X_W-1:0]), .hi (1'b0), .frac (f_co2_d), .patm (patm_s5),
		.term (term[1])
	);

	pma_lane #(.SPEC(SPEC_H2O), .BW(X_W), .SH(SH_X)) u_lane_h2o (
		.clk (clk), .v (x_quo[X_W-1:0]), .hi (1'b0), .frac (f_h2o_d), .patm (patm_s5),
		.term (term[2])
	);

	pma_lane #(.SPEC(SPEC_CO), .BW(T_W), .SH(SH_T)) u_lane_co (
		.clk (clk), .v (t_d), .hi (co_hi), .frac (f_co_d), .patm (patm_s5),
		.term (term[3])
	);

	always_ff @(posedge clk) begin
		fin_q[0] <= fin_div;
		for (int i = 1; i < FIN_N; i++) begin
			fin_q[i] <= fin_q[i-1];
		end
		pair0_s1 <= (species_present_q[0] ? term[0] : '0)
			+ (species_present_q[1] ? term[1] : '0);
		pair1_s1 <= (species_present_q[2] ? term[2] : '0)
			+ (species_present_q[3] ? term[3] : '0);
		if (tot > KABS_MAX) begin
			kabs_q <= KABS_W'(KABS_MAX);
		end else if (tot < KABS_MIN) begin
			kabs_q <= KABS_W'(KABS_MIN);
		end else begin
			kabs_q <= KABS_W'(tot);
		end
		fin_out_q <= fin_q[FIN_N-1];
	end

	assign tot             = pair0_s1 + pair1_s1;
	assign done            = vld_q[VLD_N-1];
	assign kabs            = kabs_q;
	assign final_point_out = fin_out_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_LAT done)
		else $error("result transfer missing after the pipeline latency");

	a_no_species: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(species_present_q, 2) == '0 |-> kabs == '0)
		else $error("non-zero result with every species disabled");

endmodule

`default_nettype wire
